>>> hdl/hkrb_pkg.sv
package hkrb_pkg;

    // default sizes, handed to the top level parameters
    localparam int BUTTON_COUNT_DEF = 16;
    localparam int REPORT_SLOTS_DEF = 6;

    // fixed layout
    localparam int DIRECTION_COUNT = 8;
    localparam int INDEX_W         = 5;
    localparam int BYTE_W          = 8;
    localparam int HEADER_LEN      = 4;

    // fixed report bytes
    localparam logic [BYTE_W-1:0] REPORT_ID   = 8'hA1;
    localparam logic [BYTE_W-1:0] REPORT_TYPE = 8'h01;
    localparam logic [BYTE_W-1:0] RESERVED    = 8'h00;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_WRITE   = 2'd2,
        OP_REFRESH = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SEND
    } t_state;

    // one key table entry
    typedef struct packed {
        logic              kflag;
        logic [BYTE_W-1:0] mods;
        logic [BYTE_W-1:0] code;
    } t_entry;

    // candidate travelling down the slot chain
    // code is zeroed once it is placed or found to be a duplicate
    // room tells whether the cell it last passed still had space
    typedef struct packed {
        logic              valid;
        logic              room;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] mods;
    } t_token;

endpackage

>>> hdl/hkrb_cell.sv
module hkrb_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  hkrb_pkg::t_token             i_tok,
    output hkrb_pkg::t_token             o_tok,
    output logic [hkrb_pkg::BYTE_W-1:0]  o_code
);

    logic                        r_full;
    logic [hkrb_pkg::BYTE_W-1:0] r_code;
    hkrb_pkg::t_token            r_tok;
    hkrb_pkg::t_token            n_tok;
    logic                        w_has_code;
    logic                        w_take;
    logic                        w_hit;

    // slot decision for the passing candidate
    always_comb begin
        w_has_code = i_tok.valid && (i_tok.code != '0);
        w_take     = w_has_code && !r_full;
        w_hit      = w_has_code && r_full && (r_code == i_tok.code);
        n_tok      = i_tok;
        n_tok.room = !r_full;
        if (w_take || w_hit) begin
            n_tok.code = '0;
        end
    end

    // slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_clear) begin
            r_full <= 1'b0;
        end else if (w_take) begin
            r_full <= 1'b1;
        end
    end

    // stored scan code
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_code <= i_tok.code;
        end
    end

    // hand candidate to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.room <= n_tok.room;
        r_tok.code <= n_tok.code;
        r_tok.mods <= n_tok.mods;
    end

    assign o_tok  = r_tok;
    assign o_code = r_full ? r_code : '0;

endmodule

>>> hdl/hkrb_report_out.sv
module hkrb_report_out #(
    parameter int REPORT_SLOTS = hkrb_pkg::REPORT_SLOTS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_load,
    input  logic [hkrb_pkg::BYTE_W-1:0]                  i_mods,
    input  logic [REPORT_SLOTS-1:0][hkrb_pkg::BYTE_W-1:0] i_codes,
    output logic                                         o_busy,
    output logic                                         o_out_valid,
    input  logic                                         i_out_stall,
    output logic [hkrb_pkg::BYTE_W-1:0]                  o_report_byte,
    output logic                                         o_last_byte
);

    localparam int REPORT_LEN = hkrb_pkg::HEADER_LEN + REPORT_SLOTS;
    localparam int LEFT_W     = $clog2(REPORT_LEN + 1);

    logic [hkrb_pkg::BYTE_W-1:0] r_bytes [REPORT_LEN];
    logic [LEFT_W-1:0]           r_left;
    logic                        w_take;

    assign w_take = (r_left != '0) && !i_out_stall;

    // bytes still to send
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= LEFT_W'(REPORT_LEN);
        end else if (w_take) begin
            r_left <= r_left - 1'b1;
        end
    end

    // report shift line, head byte is the one on offer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes[0] <= hkrb_pkg::REPORT_ID;
            r_bytes[1] <= hkrb_pkg::REPORT_TYPE;
            r_bytes[2] <= i_mods;
            r_bytes[3] <= hkrb_pkg::RESERVED;
            for (int k = 0; k < REPORT_SLOTS; k++) begin
                r_bytes[hkrb_pkg::HEADER_LEN + k] <= i_codes[k];
            end
        end else if (w_take) begin
            for (int k = 0; k < REPORT_LEN - 1; k++) begin
                r_bytes[k] <= r_bytes[k + 1];
            end
            r_bytes[REPORT_LEN - 1] <= '0;
        end
    end

    assign o_busy        = (r_left != '0);
    assign o_out_valid   = (r_left != '0);
    assign o_report_byte = r_bytes[0];
    assign o_last_byte   = (r_left == LEFT_W'(1));

endmodule

>>> hdl/hid_keyboard_report_builder_top.sv
// channel   valid        stall        payload
// input     i_in_valid   o_in_stall   i_opcode, i_entry_index, i_key_code,
//                                     i_modifier_mask, i_keyboard_flag
// output    o_out_valid  i_out_stall  o_report_byte, o_last_byte
//
// a press, release or refresh request starts a scan that walks one entry a cycle
// into the slot chain, then drains through it and loads the report into a shift line;
// the report bytes go out from the shift line one per cycle, unless the output stalls,
// overlapping the next request
// reset clears the pressed map, the key table and all control state at once
// output stalls only hold the report; a new report waits until the previous one is sent
module hid_keyboard_report_builder_top #(
    parameter int BUTTON_COUNT = hkrb_pkg::BUTTON_COUNT_DEF,
    parameter int REPORT_SLOTS = hkrb_pkg::REPORT_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_opcode,
    input  logic [hkrb_pkg::INDEX_W-1:0]        i_entry_index,
    input  logic [hkrb_pkg::BYTE_W-1:0]         i_key_code,
    input  logic [hkrb_pkg::BYTE_W-1:0]         i_modifier_mask,
    input  logic                                i_keyboard_flag,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hkrb_pkg::BYTE_W-1:0]         o_report_byte,
    output logic                                o_last_byte
);

    localparam int ENTRY_COUNT = BUTTON_COUNT + hkrb_pkg::DIRECTION_COUNT;
    localparam int IDX_W       = $clog2(ENTRY_COUNT);
    localparam int CMP_W       = hkrb_pkg::INDEX_W + 1;
    localparam int DRN_W       = $clog2(REPORT_SLOTS + 1);

    hkrb_pkg::t_state                         r_state;
    hkrb_pkg::t_state                         n_state;
    logic [ENTRY_COUNT-1:0]                   r_pressed;
    hkrb_pkg::t_entry                         r_table [ENTRY_COUNT];
    logic [IDX_W-1:0]                         r_scan;
    logic [DRN_W-1:0]                         r_drain;
    logic [hkrb_pkg::BYTE_W-1:0]              r_mods;

    hkrb_pkg::t_opcode                        w_op;
    logic                                     w_in_acc;
    logic                                     w_in_range;
    logic [IDX_W-1:0]                         w_idx;
    logic                                     w_start;
    logic                                     w_load;
    logic                                     w_busy;
    hkrb_pkg::t_entry                         w_entry;
    hkrb_pkg::t_token                         w_tok [REPORT_SLOTS + 1];
    logic [REPORT_SLOTS-1:0][hkrb_pkg::BYTE_W-1:0] w_codes;

    // request decode
    assign w_op       = hkrb_pkg::t_opcode'(i_opcode);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_in_range = ({1'b0, i_entry_index} < CMP_W'(ENTRY_COUNT));
    assign w_idx      = i_entry_index[IDX_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hkrb_pkg::S_IDLE: begin
                if (w_in_acc && (w_op != hkrb_pkg::OP_WRITE)) begin
                    n_state = hkrb_pkg::S_SCAN;
                end
            end
            hkrb_pkg::S_SCAN: begin
                if (r_scan == IDX_W'(ENTRY_COUNT - 1)) begin
                    n_state = hkrb_pkg::S_DRAIN;
                end
            end
            hkrb_pkg::S_DRAIN: begin
                if (r_drain == DRN_W'(REPORT_SLOTS - 1)) begin
                    n_state = hkrb_pkg::S_SEND;
                end
            end
            hkrb_pkg::S_SEND: begin
                if (!w_busy) begin
                    n_state = hkrb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hkrb_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_load     = 1'b0;
        unique case (r_state)
            hkrb_pkg::S_IDLE:  o_in_stall = 1'b0;
            hkrb_pkg::S_SCAN:  o_in_stall = 1'b1;
            hkrb_pkg::S_DRAIN: o_in_stall = 1'b1;
            hkrb_pkg::S_SEND:  w_load     = !w_busy;
            default:           o_in_stall = 1'b1;
        endcase
    end

    assign w_start = w_in_acc && (w_op != hkrb_pkg::OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkrb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // key table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRY_COUNT; e++) begin
                r_table[e] <= '0;
            end
        end else if (w_in_acc && (w_op == hkrb_pkg::OP_WRITE) && w_in_range) begin
            r_table[w_idx] <= '{kflag: i_keyboard_flag, mods: i_modifier_mask,
                                code: i_key_code};
        end
    end

    // pressed map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= '0;
        end else if (w_in_acc && w_in_range) begin
            case (w_op)
                hkrb_pkg::OP_PRESS:   r_pressed[w_idx] <= 1'b1;
                hkrb_pkg::OP_RELEASE: r_pressed[w_idx] <= 1'b0;
                default:              r_pressed <= r_pressed;
            endcase
        end
    end

    // scan and drain counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= '0;
            r_drain <= '0;
        end else begin
            if (r_state == hkrb_pkg::S_SCAN) begin
                r_scan <= r_scan + 1'b1;
            end else begin
                r_scan <= '0;
            end
            if (r_state == hkrb_pkg::S_DRAIN) begin
                r_drain <= r_drain + 1'b1;
            end else begin
                r_drain <= '0;
            end
        end
    end

    // candidate for the scanned entry; buttons need the keyboard flag
    always_comb begin
        w_entry         = r_table[r_scan];
        w_tok[0].valid  = (r_state == hkrb_pkg::S_SCAN) && r_pressed[r_scan]
                          && ((r_scan >= IDX_W'(BUTTON_COUNT)) || w_entry.kflag);
        w_tok[0].room   = 1'b1;
        w_tok[0].code   = w_entry.code;
        w_tok[0].mods   = w_entry.mods;
    end

    // slot chain
    for (genvar g = 0; g < REPORT_SLOTS; g++) begin : g_slot
        hkrb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_start),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g + 1]),
            .o_code  (w_codes[g])
        );
    end

    // modifiers count while the last slot was still free
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_mods <= '0;
        end else if (w_tok[REPORT_SLOTS].valid && w_tok[REPORT_SLOTS].room) begin
            r_mods <= r_mods | w_tok[REPORT_SLOTS].mods;
        end
    end

    // report serializer
    hkrb_report_out #(
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_mods        (r_mods),
        .i_codes       (w_codes),
        .o_busy        (w_busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_report_byte (o_report_byte),
        .o_last_byte   (o_last_byte)
    );

    // checks
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hkrb_pkg::S_SEND) |-> !w_tok[REPORT_SLOTS].valid)
        else $error("slot chain not drained before report load");

    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_report_byte == hkrb_pkg::REPORT_ID))
        else $error("report does not open with the report id");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_byte) |=> !o_out_valid)
        else $error("output still valid after the last report byte");

endmodule

>>> dv/hid_keyboard_report_builder_top_test.sv
`timescale 1ns / 1ps

module hid_keyboard_report_builder_top_test;

    localparam int BUTTON_COUNT   = hkrb_pkg::BUTTON_COUNT_DEF;
    localparam int REPORT_SLOTS   = hkrb_pkg::REPORT_SLOTS_DEF;
    localparam int ENTRY_COUNT    = BUTTON_COUNT + hkrb_pkg::DIRECTION_COUNT;
    localparam int REPORT_LEN     = hkrb_pkg::HEADER_LEN + REPORT_SLOTS;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PERCENT   = 36;

    typedef struct {
        logic [hkrb_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_report_byte;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_opcode        = hkrb_pkg::OP_REFRESH;
    logic [hkrb_pkg::INDEX_W-1:0]  i_entry_index   = '0;
    logic [hkrb_pkg::BYTE_W-1:0]   i_key_code      = '0;
    logic [hkrb_pkg::BYTE_W-1:0]   i_modifier_mask = '0;
    logic                          i_keyboard_flag = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall     = 1'b0;
    logic [hkrb_pkg::BYTE_W-1:0]   o_report_byte;
    logic                          o_last_byte;

    // shadow of the block state
    logic [ENTRY_COUNT-1:0] pressed_map = '0;
    hkrb_pkg::t_entry       key_table [ENTRY_COUNT];

    t_report_byte report_bytes_due [$];
    int           mismatch_count = 0;
    int           dead_cycles    = 0;
    bit           no_idle        = 1'b0;

    hid_keyboard_report_builder_top #(
        .BUTTON_COUNT(BUTTON_COUNT),
        .REPORT_SLOTS(REPORT_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_key_code     (i_key_code),
        .i_modifier_mask(i_modifier_mask),
        .i_keyboard_flag(i_keyboard_flag),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_report_byte  (o_report_byte),
        .o_last_byte    (o_last_byte)
    );

    always #1 i_clk = ~i_clk;

    // update the shadow state and queue the report bytes one request causes
    task automatic predict_report(input hkrb_pkg::t_opcode op,
                                  input logic [hkrb_pkg::INDEX_W-1:0] idx,
                                  input logic [hkrb_pkg::BYTE_W-1:0] code,
                                  input logic [hkrb_pkg::BYTE_W-1:0] mods,
                                  input logic kflag);
        logic [hkrb_pkg::BYTE_W-1:0] slots [REPORT_SLOTS];
        logic [hkrb_pkg::BYTE_W-1:0] modifiers;
        hkrb_pkg::t_entry            ent;
        t_report_byte                rb;
        int                          count;
        int                          i;
        int                          j;
        bit                          dup;
        modifiers = '0;
        count     = 0;
        for (i = 0; i < REPORT_SLOTS; i++) begin
            slots[i] = '0;
        end
        if (op == hkrb_pkg::OP_WRITE) begin
            if (idx < ENTRY_COUNT) begin
                key_table[idx] = '{kflag: kflag, mods: mods, code: code};
            end
            return;
        end
        if (idx < ENTRY_COUNT) begin
            if (op == hkrb_pkg::OP_PRESS) begin
                pressed_map[idx] = 1'b1;
            end else if (op == hkrb_pkg::OP_RELEASE) begin
                pressed_map[idx] = 1'b0;
            end
        end
        // scan in index order until the slots are full
        for (i = 0; i < ENTRY_COUNT && count < REPORT_SLOTS; i++) begin
            if (!pressed_map[i]) continue;
            ent = key_table[i];
            // buttons only count as keys with the keyboard flag
            if (i < BUTTON_COUNT && !ent.kflag) continue;
            if (ent.code != '0) begin
                dup = 1'b0;
                for (j = 0; j < count; j++) begin
                    if (slots[j] == ent.code) dup = 1'b1;
                end
                if (!dup) begin
                    slots[count] = ent.code;
                    count++;
                end
            end
            modifiers |= ent.mods;
        end
        for (i = 0; i < REPORT_LEN; i++) begin
            case (i)
                0: begin
                    rb.data = hkrb_pkg::REPORT_ID;
                end
                1: begin
                    rb.data = hkrb_pkg::REPORT_TYPE;
                end
                2: begin
                    rb.data = modifiers;
                end
                3: begin
                    rb.data = hkrb_pkg::RESERVED;
                end
                default: begin
                    rb.data = slots[i - hkrb_pkg::HEADER_LEN];
                end
            endcase
            rb.last = (i == REPORT_LEN - 1);
            report_bytes_due.push_back(rb);
        end
    endtask

    // drive one request, with a random idle gap ahead of it
    task automatic send_request(input hkrb_pkg::t_opcode op,
                                input logic [hkrb_pkg::INDEX_W-1:0] idx,
                                input logic [hkrb_pkg::BYTE_W-1:0] code,
                                input logic [hkrb_pkg::BYTE_W-1:0] mods,
                                input logic kflag);
        int gap;
        gap = 0;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_entry_index   <= idx;
        i_key_code      <= code;
        i_modifier_mask <= mods;
        i_keyboard_flag <= kflag;
        do @(posedge i_clk); while (o_in_stall);
        predict_report(op, idx, code, mods, kflag);
    endtask

    // unused fields of press, release and refresh carry random values
    task automatic press_entry(input logic [hkrb_pkg::INDEX_W-1:0] idx);
        send_request(hkrb_pkg::OP_PRESS, idx, $urandom, $urandom, $urandom);
    endtask

    task automatic release_entry(input logic [hkrb_pkg::INDEX_W-1:0] idx);
        send_request(hkrb_pkg::OP_RELEASE, idx, $urandom, $urandom, $urandom);
    endtask

    task automatic refresh_report();
        send_request(hkrb_pkg::OP_REFRESH, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic write_entry(input logic [hkrb_pkg::INDEX_W-1:0] idx,
                               input logic [hkrb_pkg::BYTE_W-1:0] code,
                               input logic [hkrb_pkg::BYTE_W-1:0] mods, input logic kflag);
        send_request(hkrb_pkg::OP_WRITE, idx, code, mods, kflag);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
        mismatch_count++;
    endtask

    // reports from an empty table and an empty pressed map
    task automatic test_empty_reports();
        refresh_report();
        press_entry(0);
        release_entry(0);
    endtask

    // button keyboard flag, extremes of code and modifiers, directions always count
    task automatic test_entry_kinds();
        write_entry(0, 8'h04, 8'h00, 1'b0);
        press_entry(0);
        write_entry(1, 8'hFF, 8'hFF, 1'b1);
        press_entry(1);
        write_entry(BUTTON_COUNT, 8'h52, 8'h01, 1'b0);
        press_entry(BUTTON_COUNT);
    endtask

    // duplicate codes add modifiers only, zero code adds modifiers only
    task automatic test_duplicate_codes();
        write_entry(BUTTON_COUNT + 1, 8'hFF, 8'h80, 1'b0);
        press_entry(BUTTON_COUNT + 1);
        write_entry(2, 8'h00, 8'h02, 1'b1);
        press_entry(2);
    endtask

    // full slots stop the scan, later modifiers dropped
    task automatic test_full_slots();
        int k;
        for (k = 3; k < 7; k++) begin
            write_entry(k, 8'h10 + k, 8'h00, 1'b1);
            press_entry(k);
        end
    endtask

    // indexes past the last entry: writes dropped, press and release still report
    task automatic test_out_of_range();
        write_entry(31, 8'h33, 8'h44, 1'b1);
        press_entry(31);
        release_entry(ENTRY_COUNT);
        release_entry(1);
    endtask

    // table loads mixed with press and release traffic
    task automatic test_random_traffic(input int item_count);
        logic [hkrb_pkg::INDEX_W-1:0] idx;
        logic [hkrb_pkg::BYTE_W-1:0]  code;
        int                           pick;
        int                           n;
        for (n = 0; n < item_count; n++) begin
            no_idle = (n >= item_count / 3) && (n < 2 * item_count / 3);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) begin
                idx = $urandom_range(ENTRY_COUNT, 31);
            end else begin
                idx = $urandom_range(0, ENTRY_COUNT - 1);
            end
            // small code pool makes duplicates common
            if ($urandom_range(0, 3) == 0) begin
                code = $urandom_range(4, 7);
            end else begin
                code = $urandom;
            end
            if (pick < 25) begin
                write_entry(idx, code, $urandom, $urandom);
            end else if (pick < 60) begin
                press_entry(idx);
            end else if (pick < 95) begin
                release_entry(idx);
            end else begin
                refresh_report();
            end
        end
        no_idle = 1'b0;
    endtask

    // output side stalls at random, except while no_idle is set
    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // check each report byte against the oldest expectation
    always @(posedge i_clk) begin
        t_report_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (report_bytes_due.size() == 0) begin
                report_mismatch("unexpected report byte", o_report_byte, 0);
            end else begin
                want = report_bytes_due.pop_front();
                if (o_report_byte !== want.data) begin
                    report_mismatch("report_byte", o_report_byte, want.data);
                end
                if (o_last_byte !== want.last) begin
                    report_mismatch("last_byte", o_last_byte, want.last);
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            dead_cycles <= 0;
        end else begin
            dead_cycles <= dead_cycles + 1;
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        wait (dead_cycles >= WATCHDOG_LIMIT);
        $display("hid_keyboard_report_builder_top_test failed");
        $finish;
    end

    initial begin
        int k;
        for (k = 0; k < ENTRY_COUNT; k++) begin
            key_table[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_reports();
        test_entry_kinds();
        test_duplicate_codes();
        test_full_slots();
        test_out_of_range();
        test_random_traffic(155);
        i_in_valid <= 1'b0;
        while (report_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("hid_keyboard_report_builder_top_test passed");
        end else begin
            $display("hid_keyboard_report_builder_top_test failed");
        end
        $finish;
    end

endmodule
